>>> rtl/core/image_column_envelope_gain_core_macros.svh
// Assertion macros used by the checker of the envelope gain core.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef IMAGE_COLUMN_ENVELOPE_GAIN_CORE_MACROS_SVH
`define IMAGE_COLUMN_ENVELOPE_GAIN_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icg check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define ICG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icg check failed: next-cycle rule");

`endif

>>> rtl/core/icg_pkg.sv
// Package of the envelope gain core: default sizes, reset constants and types.
// Used by every module of the core except icg_fifo; depends on nothing.
`timescale 1ns / 1ps

package icg_pkg;

  localparam int unsigned ColumnsDefault    = 960;
  localparam int unsigned RowsDefault       = 960;
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned PhaseW   = 32;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned PixelW   = 10;
  localparam int unsigned WordBits = 32;

  localparam logic [PhaseW-1:0] StepReset = 32'd89478;

  typedef enum logic {
    OP_WRITE,
    OP_SAMPLE
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_SC_RD,
    ST_SC_CHK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } back_state_e;

endpackage

>>> rtl/core/image_column_envelope_gain_core.sv
// Envelope gain core. A pixel write reads and writes back one memory word in the back
// end; a sample scans the column's 32-row words in turn (at most ceil(ROWS/32)) until
// one holds a lit pixel or the last is read, then scales the sample, dividing by ROWS
// through a reciprocal multiply taken 16 bits a cycle.
// After reset the image memory is cleared, one word a cycle, COLUMNS*ceil(ROWS/32)
// words (28800 by default); in_ready_o stays low meanwhile, configuration is taken.
`timescale 1ns / 1ps

module image_column_envelope_gain_core #(
  parameter int unsigned COLUMNS     = icg_pkg::ColumnsDefault,
  parameter int unsigned ROWS        = icg_pkg::RowsDefault,
  parameter int unsigned QUEUE_DEPTH = icg_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [icg_pkg::PixelW-1:0]          pixel_col_i,
  input  logic [icg_pkg::PixelW-1:0]          pixel_row_i,
  input  logic                                pixel_lit_i,
  input  logic signed [icg_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [icg_pkg::PhaseW-1:0]          cfg_phase_step_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [icg_pkg::SampleW-1:0]  sample_out_o
);

  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned RIW = $clog2(ROWS);
  localparam int unsigned SW  = icg_pkg::SampleW;
  localparam int unsigned DW  = 1 + CW + RIW + 1 + SW;

  logic                push_valid, push_ready, push_lit, pop_valid, pop_ready, clear_busy;
  icg_pkg::op_e        push_op;
  logic [CW-1:0]       push_col;
  logic [RIW-1:0]      push_row;
  logic signed [SW-1:0] push_sample;
  logic [DW-1:0]       push_data, pop_data;

  icg_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .pixel_col_i      (pixel_col_i),
    .pixel_row_i      (pixel_row_i),
    .pixel_lit_i      (pixel_lit_i),
    .sample_in_i      (sample_in_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_phase_step_i (cfg_phase_step_i),
    .clear_busy_i     (clear_busy),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_op_o        (push_op),
    .push_col_o       (push_col),
    .push_row_o       (push_row),
    .push_lit_o       (push_lit),
    .push_sample_o    (push_sample)
  );

  assign push_data = {push_op, push_col, push_row, push_lit, push_sample};

  icg_fifo #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  icg_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_op_i     (icg_pkg::op_e'(pop_data[DW-1])),
    .pop_col_i    (pop_data[DW-2 -: CW]),
    .pop_row_i    (pop_data[SW+RIW:SW+1]),
    .pop_lit_i    (pop_data[SW]),
    .pop_sample_i ($signed(pop_data[SW-1:0])),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule

>>> rtl/core/icg_fifo.sv
// Short queue between the front and back parts of the envelope gain core.
// Generic width and depth; no dependencies.
`timescale 1ns / 1ps

module icg_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);

  localparam int unsigned PTRW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   slot_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CNTW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/core/icg_front.sv
// Front part of the envelope gain core: input transfer, phase accumulator,
// column lookup and pixel range check. Depends on icg_pkg.
`timescale 1ns / 1ps

module icg_front #(
  parameter int unsigned COLUMNS = icg_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = icg_pkg::RowsDefault,
  localparam int unsigned CW     = $clog2(COLUMNS),
  localparam int unsigned RIW    = $clog2(ROWS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [icg_pkg::PixelW-1:0]          pixel_col_i,
  input  logic [icg_pkg::PixelW-1:0]          pixel_row_i,
  input  logic                                pixel_lit_i,
  input  logic signed [icg_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [icg_pkg::PhaseW-1:0]          cfg_phase_step_i,
  input  logic                                clear_busy_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output icg_pkg::op_e                        push_op_o,
  output logic [CW-1:0]                       push_col_o,
  output logic [RIW-1:0]                      push_row_o,
  output logic                                push_lit_o,
  output logic signed [icg_pkg::SampleW-1:0]  push_sample_o
);

  localparam int unsigned PW = icg_pkg::PhaseW;

  logic [PW-1:0]                      step_q;
  logic [PW-1:0]                      phase_q;
  logic                               hold_valid_q, hold_valid_d;
  logic                               hold_kind_q;
  logic [icg_pkg::PixelW-1:0]         hold_col_q;
  logic [icg_pkg::PixelW-1:0]         hold_row_q;
  logic                               hold_lit_q;
  logic signed [icg_pkg::SampleW-1:0] hold_sample_q;
  logic [PW-1:0]                      hold_phase_q;
  logic [PW+CW-1:0]                   col_prod;
  logic                               in_range, drop, consume, accept;

  assign cfg_ready_o = 1'b1;

  assign in_range = (32'(hold_col_q) < COLUMNS) && (32'(hold_row_q) < ROWS);
  assign drop     = hold_valid_q && !hold_kind_q && !in_range;
  assign consume  = drop || (push_valid_o && push_ready_i);
  assign accept   = in_valid_i && in_ready_o;

  assign in_ready_o   = !clear_busy_i && (!hold_valid_q || consume);
  assign push_valid_o = hold_valid_q && !drop;

  assign col_prod      = (PW + CW)'(hold_phase_q) * (PW + CW)'(COLUMNS);
  assign push_op_o     = hold_kind_q ? icg_pkg::OP_SAMPLE : icg_pkg::OP_WRITE;
  assign push_col_o    = hold_kind_q ? col_prod[PW+CW-1:PW] : CW'(hold_col_q);
  assign push_row_o    = RIW'(hold_row_q);
  assign push_lit_o    = hold_lit_q;
  assign push_sample_o = hold_sample_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (consume) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= icg_pkg::StepReset;
      phase_q      <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      if (cfg_valid_i) begin
        step_q <= cfg_phase_step_i;
      end
      if (accept && kind_i) begin
        phase_q <= phase_q + step_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_kind_q   <= kind_i;
      hold_col_q    <= pixel_col_i;
      hold_row_q    <= pixel_row_i;
      hold_lit_q    <= pixel_lit_i;
      hold_sample_q <= sample_in_i;
      hold_phase_q  <= phase_q;
    end
  end

endmodule

>>> rtl/core/icg_back.sv
// Back part of the envelope gain core: image memory with its clearing pass,
// column scan, sample scaling and output register. Depends on icg_pkg.
`timescale 1ns / 1ps

module icg_back #(
  parameter int unsigned COLUMNS = icg_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = icg_pkg::RowsDefault,
  localparam int unsigned CW     = $clog2(COLUMNS),
  localparam int unsigned RIW    = $clog2(ROWS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  icg_pkg::op_e                        pop_op_i,
  input  logic [CW-1:0]                       pop_col_i,
  input  logic [RIW-1:0]                      pop_row_i,
  input  logic                                pop_lit_i,
  input  logic signed [icg_pkg::SampleW-1:0]  pop_sample_i,
  output logic                                clear_busy_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [icg_pkg::SampleW-1:0]  sample_out_o
);

  localparam int unsigned SW    = icg_pkg::SampleW;
  localparam int unsigned W     = icg_pkg::WordBits;
  localparam int unsigned WB    = $clog2(W);
  localparam int unsigned RW    = (ROWS + W - 1) / W;
  localparam int unsigned DEPTH = COLUMNS * RW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WCW   = $clog2(RW + 1);
  localparam int unsigned RCW   = $clog2(ROWS + 1);
  localparam int unsigned PW    = SW + RCW;
  localparam int unsigned KS    = PW + RIW;
  localparam longint unsigned Recip = ((64'd1 << KS) + 64'(ROWS) - 64'd1) / 64'(ROWS);
  localparam int unsigned CH    = 16;
  localparam int unsigned NCH   = (PW + 2 + CH - 1) / CH;
  localparam int unsigned MP    = NCH * CH;
  localparam int unsigned ACCW  = PW + MP;
  localparam logic [MP-1:0] RecipPad = MP'(Recip);
  localparam int unsigned CNTW  = $clog2(NCH + 1);

  icg_pkg::back_state_e state_q, state_d;

  logic [W-1:0]    mem [DEPTH];
  logic [W-1:0]    rdata_q;
  logic [AW-1:0]   clr_q;
  logic [AW-1:0]   addr_q;
  logic [WCW-1:0]  word_q;
  logic [WB-1:0]   bsel_q;
  logic            lit_q;
  logic [SW-1:0]   mag_q;
  logic            neg_q;
  logic [RCW-1:0]  r_q;
  logic [PW-1:0]   dq_q;
  logic [ACCW-1:0] acc_q;
  logic [MP-1:0]   rec_q;
  logic [CNTW-1:0] cnt_q;
  logic            out_valid_q;
  logic [SW-1:0]   out_data_q;

  logic            pop, word_hit, last_word, div_last, out_free;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [W-1:0]    mem_wd, wr_word;
  logic [PW+CH-1:0] prod;
  logic [SW-1:0]   quot;
  logic [31:0]     row_word;

  function automatic logic [WB-1:0] first_lit(input logic [W-1:0] w);
    logic [WB-1:0] idx;
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = WB'(i);
      end
    end
    return idx;
  endfunction

  assign pop_ready_o  = (state_q == icg_pkg::ST_IDLE);
  assign pop          = pop_valid_i && pop_ready_o;
  assign clear_busy_o = (state_q == icg_pkg::ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  assign word_hit  = (rdata_q != '0);
  assign last_word = (word_q == WCW'(RW - 1));
  assign div_last  = (cnt_q == CNTW'(NCH - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign prod      = (PW + CH)'(dq_q) * (PW + CH)'(rec_q[MP-1 -: CH]);
  assign quot      = acc_q[KS +: SW];
  assign row_word  = (pop_op_i == icg_pkg::OP_WRITE) ? (32'(pop_row_i) >> WB) : 32'd0;

  always_comb begin
    wr_word         = rdata_q;
    wr_word[bsel_q] = lit_q;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = wr_word;
    if (state_q == icg_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (state_q == icg_pkg::ST_WR_WB) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icg_pkg::ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = icg_pkg::ST_IDLE;
        end
      end
      icg_pkg::ST_IDLE: begin
        if (pop) begin
          state_d = (pop_op_i == icg_pkg::OP_WRITE) ? icg_pkg::ST_WR_RD : icg_pkg::ST_SC_RD;
        end
      end
      icg_pkg::ST_WR_RD:  state_d = icg_pkg::ST_WR_WB;
      icg_pkg::ST_WR_WB:  state_d = icg_pkg::ST_IDLE;
      icg_pkg::ST_SC_RD:  state_d = icg_pkg::ST_SC_CHK;
      icg_pkg::ST_SC_CHK: begin
        state_d = (word_hit || last_word) ? icg_pkg::ST_MUL : icg_pkg::ST_SC_RD;
      end
      icg_pkg::ST_MUL:    state_d = icg_pkg::ST_DIV;
      icg_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = icg_pkg::ST_DONE;
        end
      end
      icg_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = icg_pkg::ST_IDLE;
        end
      end
      default: state_d = icg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= icg_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == icg_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == icg_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The product with the row count is divided by ROWS through a multiply by its
  // rounded-up reciprocal, taken 16 bits of the reciprocal a cycle.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      icg_pkg::ST_IDLE: begin
        if (pop) begin
          addr_q <= AW'(32'(pop_col_i) * RW + row_word);
          bsel_q <= WB'(32'(pop_row_i) & (W - 1));
          lit_q  <= pop_lit_i;
          word_q <= '0;
          neg_q  <= pop_sample_i[SW-1];
          mag_q  <= pop_sample_i[SW-1] ? SW'(-pop_sample_i) : SW'(pop_sample_i);
        end
      end
      icg_pkg::ST_SC_CHK: begin
        if (word_hit) begin
          r_q <= RCW'(32'(word_q) * W + 32'(first_lit(rdata_q)));
        end else if (last_word) begin
          r_q <= RCW'(ROWS);
        end else begin
          word_q <= word_q + 1'b1;
          addr_q <= addr_q + 1'b1;
        end
      end
      icg_pkg::ST_MUL: begin
        dq_q  <= PW'(mag_q) * PW'(r_q);
        acc_q <= '0;
        rec_q <= RecipPad;
        cnt_q <= '0;
      end
      icg_pkg::ST_DIV: begin
        acc_q <= (acc_q << CH) + ACCW'(prod);
        rec_q <= rec_q << CH;
        cnt_q <= cnt_q + 1'b1;
      end
      icg_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_q <= neg_q ? (~quot + SW'(1)) : quot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[addr_q];
  end

endmodule

>>> rtl/core/icg_checker.sv
// Port-level checks of the envelope gain core, bound to its top level.
// Depends on icg_pkg and image_column_envelope_gain_core_macros.svh.
`timescale 1ns / 1ps
`include "image_column_envelope_gain_core_macros.svh"

module icg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [icg_pkg::SampleW-1:0]  sample_out_o
);

  logic out_xfer;

  assign out_xfer = out_valid_o && out_ready_i;

  // A stalled result keeps its value until its transfer.
  `ICG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_out_o))

  // The phase step register takes a write in any cycle.
  `ICG_ASSERT_SAME(a_cfg_ready, cfg_valid_i, cfg_ready_o)

  // Only one finished result waits, and a new one needs a full scan and scaling.
  `ICG_ASSERT_NEXT(a_no_triple, out_xfer ##1 out_xfer, !out_xfer)

endmodule

bind image_column_envelope_gain_core icg_checker u_icg_checker (.*);
